// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the checker files of this block.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge out of reset.
`define PEE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that the consequent holds in the clock cycle after the antecedent.
`define PEE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/pee_pkg.sv =====
// Package of the postfix evaluator: widths, character codes, status codes
// and the request and response types of the divider. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pee_pkg;

	localparam int PEE_STACK_DEPTH = 16;
	localparam int DATA_W = 32;

	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_LPAREN  = 8'h28;
	localparam logic [7:0] CH_RPAREN  = 8'h29;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_UNDERFLOW = 3'd1;
	localparam logic [2:0] ST_OVERFLOW  = 3'd2;
	localparam logic [2:0] ST_DIVZERO   = 3'd3;
	localparam logic [2:0] ST_PAREN     = 3'd4;

	typedef struct packed {
		logic              start;
		logic              want_rem;
		logic [DATA_W-1:0] dividend;
		logic [DATA_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] value;
	} div_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pee_div.sv =====
// Iterative radix-2 signed divider, one quotient bit per cycle.
// Depends on pee_pkg for the request and response types.
`timescale 1ns / 1ps
`default_nettype none

module pee_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  pee_pkg::div_req_t      req,
	output pee_pkg::div_rsp_t      rsp
);

	localparam int W = pee_pkg::DATA_W;
	localparam int CNT_W = $clog2(W);

	logic [W-1:0]     rem_q;
	logic [W-1:0]     quo_q;
	logic [W-1:0]     dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             qneg_q;
	logic             rneg_q;
	logic             want_rem_q;

	logic [W:0]   shifted;
	logic [W:0]   diff;
	logic [W-1:0] dvd_abs;
	logic [W-1:0] dvs_abs;

	assign dvd_abs = req.dividend[W-1] ? (~req.dividend + W'(1)) : req.dividend;
	assign dvs_abs = req.divisor[W-1]  ? (~req.divisor + W'(1))  : req.divisor;
	assign shifted = {rem_q, quo_q[W-1]};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q      <= '0;
			quo_q      <= dvd_abs;
			dvs_q      <= dvs_abs;
			qneg_q     <= req.dividend[W-1] ^ req.divisor[W-1];
			rneg_q     <= req.dividend[W-1];
			want_rem_q <= req.want_rem;
		end else if (busy_q) begin
			if (!diff[W]) begin
				rem_q <= diff[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		rsp.done = done_q;
		if (want_rem_q) begin
			rsp.value = rneg_q ? (~rem_q + W'(1)) : rem_q;
		end else begin
			rsp.value = qneg_q ? (~quo_q + W'(1)) : quo_q;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/postfix_expression_evaluator_unit.sv =====
// Postfix expression evaluator: operand stack memory, sequencer and shared ALU.
// Depends on pee_pkg and pee_div.
//
//   channel   direction  handshake             payload
//   sym       in         sym_valid/sym_stall   symbol_char
//   res       out        res_valid/res_stall   result_value, status
//
// Operand and parenthesis characters, characters ignored after an error and an
// operator short of operands are taken in S_IDLE alone; + - * pass through S_RDA
// and S_EXEC; / and % then wait in S_DIV for the radix-2 divider unless b is zero.
// A space leads to S_EMIT, which waits for res_stall to drop while a result is held.
// Reset clears the stack count, the error and the output valid; no sweep.
// A pending result waits in the output register while the next item is taken.
`timescale 1ns / 1ps
`default_nettype none

module postfix_expression_evaluator_unit #(
	parameter int STACK_DEPTH = pee_pkg::PEE_STACK_DEPTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               sym_valid,
	output logic                    sym_stall,
	input  wire logic [7:0]         symbol_char,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output logic signed [31:0]      result_value,
	output logic [2:0]              status
);

	localparam int W  = pee_pkg::DATA_W;
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_SPC  = 6'b000010,
		S_RDA  = 6'b000100,
		S_EXEC = 6'b001000,
		S_DIV  = 6'b010000,
		S_EMIT = 6'b100000
	} state_t;

	state_t        state_q;
	logic [CW-1:0] count_q;
	logic [2:0]    err_q;
	logic [7:0]    op_q;
	logic [W-1:0]  b_q;
	logic [W-1:0]  res_q;
	logic [2:0]    st_q;
	logic [W-1:0]  rdata_q;
	logic [W-1:0]  mem_q [STACK_DEPTH];

	logic          accept;
	logic          is_space;
	logic          is_paren;
	logic          is_op;
	logic          is_divmod;
	logic [CW-1:0] top_cnt;
	logic [CW-1:0] sec_cnt;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [W-1:0]  wr_data;
	logic [W-1:0]  alu_out;
	logic          push_ok;
	logic          emit_load;

	pee_pkg::div_req_t div_req;
	pee_pkg::div_rsp_t div_rsp;

	assign sym_stall = (state_q != S_IDLE);
	assign accept    = sym_valid && !sym_stall;

	assign is_space = (symbol_char == pee_pkg::CH_SPACE);
	assign is_paren = (symbol_char == pee_pkg::CH_LPAREN) || (symbol_char == pee_pkg::CH_RPAREN);
	assign is_op    = (symbol_char == pee_pkg::CH_PLUS) || (symbol_char == pee_pkg::CH_MINUS) ||
	                  (symbol_char == pee_pkg::CH_STAR) || (symbol_char == pee_pkg::CH_SLASH) ||
	                  (symbol_char == pee_pkg::CH_PERCENT);
	assign is_divmod = (op_q == pee_pkg::CH_SLASH) || (op_q == pee_pkg::CH_PERCENT);

	assign top_cnt = count_q - CW'(1);
	assign sec_cnt = count_q - CW'(2);
	assign rd_addr = (state_q == S_RDA) ? sec_cnt[AW-1:0] : top_cnt[AW-1:0];

	assign push_ok = accept && !is_space && (err_q == pee_pkg::ST_OK) && !is_paren && !is_op &&
	                 (count_q < CW'(STACK_DEPTH));

	always_comb begin
		case (op_q)
			pee_pkg::CH_PLUS:  alu_out = rdata_q + b_q;
			pee_pkg::CH_MINUS: alu_out = rdata_q - b_q;
			default:           alu_out = W'(rdata_q * b_q);
		endcase
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = sec_cnt[AW-1:0];
		wr_data = alu_out;
		case (state_q)
			S_IDLE: begin
				wr_en   = push_ok;
				wr_addr = count_q[AW-1:0];
				wr_data = {{(W-8){1'b0}}, symbol_char} - {{(W-8){1'b0}}, pee_pkg::CH_ZERO};
			end
			S_EXEC: begin
				wr_en = !is_divmod;
			end
			S_DIV: begin
				wr_en   = div_rsp.done;
				wr_data = div_rsp.value;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_comb begin
		div_req.start    = (state_q == S_EXEC) && is_divmod && (b_q != '0);
		div_req.want_rem = (op_q == pee_pkg::CH_PERCENT);
		div_req.dividend = rdata_q;
		div_req.divisor  = b_q;
	end

	pee_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rdata_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			err_q   <= pee_pkg::ST_OK;
			op_q    <= '0;
			b_q     <= '0;
			res_q   <= '0;
			st_q    <= pee_pkg::ST_OK;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (is_space) begin
							if (err_q != pee_pkg::ST_OK) begin
								res_q   <= '0;
								st_q    <= err_q;
								count_q <= '0;
								err_q   <= pee_pkg::ST_OK;
								state_q <= S_EMIT;
							end else if (count_q == '0) begin
								res_q   <= '0;
								st_q    <= pee_pkg::ST_UNDERFLOW;
								state_q <= S_EMIT;
							end else begin
								state_q <= S_SPC;
							end
						end else if (err_q != pee_pkg::ST_OK) begin
							err_q <= err_q;
						end else if (is_paren) begin
							err_q <= pee_pkg::ST_PAREN;
						end else if (is_op) begin
							if (count_q < CW'(2)) begin
								err_q <= pee_pkg::ST_UNDERFLOW;
							end else begin
								op_q    <= symbol_char;
								state_q <= S_RDA;
							end
						end else if (push_ok) begin
							count_q <= count_q + CW'(1);
						end else begin
							err_q <= pee_pkg::ST_OVERFLOW;
						end
					end
				end
				S_SPC: begin
					res_q   <= rdata_q;
					st_q    <= pee_pkg::ST_OK;
					count_q <= '0;
					state_q <= S_EMIT;
				end
				S_RDA: begin
					b_q     <= rdata_q;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (is_divmod && (b_q == '0)) begin
						err_q   <= pee_pkg::ST_DIVZERO;
						state_q <= S_IDLE;
					end else if (is_divmod) begin
						state_q <= S_DIV;
					end else begin
						count_q <= count_q - CW'(1);
						state_q <= S_IDLE;
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						count_q <= count_q - CW'(1);
						state_q <= S_IDLE;
					end
				end
				S_EMIT: begin
					if (emit_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign emit_load = (state_q == S_EMIT) && (!res_valid || !res_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (emit_load) begin
			res_valid <= 1'b1;
		end else if (!res_stall) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			result_value <= res_q;
			status       <= st_q;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/pee_checker.sv =====
// Port-level checker of the postfix evaluator, bound to the top level.
// Depends on assert_macros.svh and pee_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pee_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               sym_valid,
	input wire logic               sym_stall,
	input wire logic [7:0]         symbol_char,
	input wire logic               res_valid,
	input wire logic               res_stall,
	input wire logic signed [31:0] result_value,
	input wire logic [2:0]         status
);

	`PEE_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(result_value) && $stable(status), "stalled result item changed")
	`PEE_ASSERT(a_err_zero, !res_valid || (status == pee_pkg::ST_OK) || (result_value == 32'sd0), "error result item carries a nonzero value")
	`PEE_ASSERT_NEXT(a_no_spurious, sym_valid && !sym_stall && (symbol_char != pee_pkg::CH_SPACE) && !res_valid, !res_valid, "result item without a space")
	`PEE_ASSERT_NEXT(a_space_busy, sym_valid && !sym_stall && (symbol_char == pee_pkg::CH_SPACE), sym_stall, "space item did not hold off the input")

endmodule

bind postfix_expression_evaluator_unit pee_checker u_pee_checker (.*);

`default_nettype wire
